// File: hdl/rpas_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Range progression add / range sum: shared package
// Constants, sequencer states, multiplier request types and modular helpers.
// ---------------------------------------------------------------------------
package rpas_pkg;

    // Residue width and position width.
    localparam int VAL_W = 30;
    localparam int POS_W = 11;

    // Prime modulus, one bit wider than a residue for compare and subtract.
    localparam logic [VAL_W:0] MODP = 31'd1000000007;

    // Default number of leaves.
    localparam int LEAF_COUNT_DEF = 1024;

    // Largest length that the position fields can express.
    localparam int POS_MAX = (1 << POS_W) - 1;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ANCHOR,
        ST_ANCHOR_W,
        ST_POP,
        ST_VISIT,
        ST_COV_W,
        ST_COV,
        ST_PD_W,
        ST_PD,
        ST_PD_R,
        ST_PD_CLR,
        ST_PD_ZERO,
        ST_PUSH_MG,
        ST_PUSH_R,
        ST_PUSH_L,
        ST_MG_W1,
        ST_MG_1,
        ST_MG_W2,
        ST_MG_2,
        ST_MG_WR,
        ST_AP_TRI,
        ST_AP_M1,
        ST_AP_M2,
        ST_AP_M3,
        ST_AP_WR,
        ST_DONE
    } t_state;

    // Request to the shared modular multiplier.
    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] x;
        logic [VAL_W-1:0] y;
    } t_mul_req;

    // Response from the shared modular multiplier.
    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] prod;
    } t_mul_rsp;

    // Sum of two residues, reduced.
    function automatic logic [VAL_W-1:0] modadd(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= MODP) ? VAL_W'(s - MODP) : VAL_W'(s);
    endfunction

    // Difference of two residues, reduced.
    function automatic logic [VAL_W-1:0] modsub(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + MODP - {1'b0, b});
        return VAL_W'(s);
    endfunction

    // Reduce a raw 30-bit value, which is always below twice the modulus.
    function automatic logic [VAL_W-1:0] modred(input logic [VAL_W-1:0] a);
        return ({1'b0, a} >= MODP) ? VAL_W'({1'b0, a} - MODP) : a;
    endfunction

endpackage

// File: hdl/rpas_modmul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Range progression add / range sum: modular multiplier
// Bit-serial shift-and-add multiplier modulo the prime, one bit per cycle.
// ---------------------------------------------------------------------------
module rpas_modmul
    import rpas_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    localparam int CNT_W = $clog2(VAL_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [VAL_W-1:0] r_acc;
    logic [VAL_W-1:0] r_x;
    logic [VAL_W-1:0] r_y;

    logic [VAL_W:0]   w_dbl;
    logic [VAL_W-1:0] w_dbl_red;
    logic [VAL_W:0]   w_add;
    logic [VAL_W-1:0] w_next;

    // One step: double the accumulator, then add the multiplicand if the bit is set.
    always_comb begin
        w_dbl     = {r_acc, 1'b0};
        w_dbl_red = (w_dbl >= MODP) ? VAL_W'(w_dbl - MODP) : VAL_W'(w_dbl);
        w_add     = {1'b0, w_dbl_red} + (r_y[VAL_W-1] ? {1'b0, r_x} : '0);
        w_next    = (w_add >= MODP) ? VAL_W'(w_add - MODP) : VAL_W'(w_add);
    end

    // Iteration control and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_acc  <= '0;
                r_x    <= i_req.x;
                r_y    <= i_req.y;
                r_cnt  <= CNT_W'(VAL_W - 1);
            end else if (r_busy) begin
                r_acc <= w_next;
                r_y   <= {r_y[VAL_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

// File: hdl/rpas_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Range progression add / range sum: node store
// Single-port memory with registered read data, one word per tree node.
// ---------------------------------------------------------------------------
module rpas_ram
    import rpas_pkg::*;
#(
    parameter int AW = 11
)
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [VAL_W-1:0] i_wdata,
    output logic [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] r_mem [0:(1 << AW)-1];

    // Write and registered read at the same address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// File: hdl/range_progression_add_sum_tree.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Range progression add / range sum tree
// Lazy segment tree modulo 1000000007 with arithmetic-progression range add
// and range sum, walked by a sequencer around one shared modular multiplier.
// ---------------------------------------------------------------------------
// Usage:
// Requests enter on i_in_valid / o_in_stall. kind 0 adds
// slope*(i - range_low) + offset to positions range_low..range_high, kind 1
// returns the range sum on o_out_valid / i_out_stall; updates give no result.
// The length register is written on i_cfg_valid / o_cfg_ready while idle, and
// every write clears the whole array.
// After reset and after each length write a clearing pass over all 2^NODE_W
// node addresses (2048 at the default) runs before the first request is taken.
// One request is processed at a time. Each tag application runs three passes
// of the bit-serial multiplier, and the anchor term takes one more pass.
// The time a request takes grows with the frames visited and the tags applied,
// and is set mostly by the multiplier.
// A result waits in the output register while i_out_stall is high; the next
// request is still accepted and is held back only when its own result is due.
// ---------------------------------------------------------------------------
module range_progression_add_sum_tree
    import rpas_pkg::*;
#(
    parameter int LEAF_COUNT = LEAF_COUNT_DEF
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_kind,
    input  logic [POS_W-1:0] i_range_low,
    input  logic [POS_W-1:0] i_range_high,
    input  logic [VAL_W-1:0] i_slope,
    input  logic [VAL_W-1:0] i_offset,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [VAL_W-1:0] o_range_sum,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [POS_W-1:0] i_cfg_data
);

    localparam int NODE_W  = $clog2(LEAF_COUNT) + 1;
    localparam int STK_D   = 2 * NODE_W + 2;
    localparam int STK_AW  = $clog2(STK_D);
    localparam int SP_W    = $clog2(STK_D + 1);
    localparam int MAX_LEN = (LEAF_COUNT > POS_MAX) ? POS_MAX : LEAF_COUNT;

    // Control registers.
    t_state            r_state, n_state;
    t_state            r_ret, n_ret;
    logic [SP_W-1:0]   r_sp, n_sp;
    logic [NODE_W-1:0] r_addr, n_addr;
    logic [POS_W-1:0]  r_len, n_len;
    logic              r_out_valid, n_out_valid;

    // Datapath registers.
    logic              r_kind, n_kind;
    logic [POS_W-1:0]  r_u, n_u;
    logic [POS_W-1:0]  r_v, n_v;
    logic [VAL_W-1:0]  r_a, n_a;
    logic [VAL_W-1:0]  r_b, n_b;
    logic [VAL_W-1:0]  r_c, n_c;
    logic [VAL_W-1:0]  r_acc, n_acc;
    logic [NODE_W-1:0] r_node, n_node;
    logic [POS_W-1:0]  r_lo, n_lo;
    logic [POS_W-1:0]  r_hi, n_hi;
    logic              r_merge, n_merge;
    logic [POS_W-1:0]  r_tl, n_tl;
    logic [POS_W-1:0]  r_tr, n_tr;
    logic [VAL_W-1:0]  r_tc_in, n_tc_in;
    logic [VAL_W-1:0]  r_ts_in, n_ts_in;
    logic [VAL_W-1:0]  r_pc, n_pc;
    logic [VAL_W-1:0]  r_ps, n_ps;
    logic [VAL_W-1:0]  r_tri, n_tri;
    logic [VAL_W-1:0]  r_t1, n_t1;
    logic [VAL_W-1:0]  r_out_sum, n_out_sum;

    // Walk stack.
    logic [NODE_W-1:0] r_stk_node [0:STK_D-1];
    logic [POS_W-1:0]  r_stk_lo   [0:STK_D-1];
    logic [POS_W-1:0]  r_stk_hi   [0:STK_D-1];
    logic              r_stk_mg   [0:STK_D-1];

    logic              w_push;
    logic [NODE_W-1:0] w_push_node;
    logic [POS_W-1:0]  w_push_lo;
    logic [POS_W-1:0]  w_push_hi;
    logic              w_push_mg;
    logic [STK_AW-1:0] w_top;

    // Node store interface.
    logic              w_we_sum;
    logic              w_we_tag;
    logic [VAL_W-1:0]  w_wd_sum;
    logic [VAL_W-1:0]  w_wd_tc;
    logic [VAL_W-1:0]  w_wd_ts;
    logic [VAL_W-1:0]  w_rd_sum;
    logic [VAL_W-1:0]  w_rd_tc;
    logic [VAL_W-1:0]  w_rd_ts;

    // Multiplier interface.
    t_mul_req          w_mul_req;
    t_mul_rsp          w_mul_rsp;

    // Helper values.
    logic [NODE_W-1:0] w_left;
    logic [NODE_W-1:0] w_right;
    logic [POS_W:0]    w_lh;
    logic [POS_W-1:0]  w_mid;
    logic [POS_W-1:0]  w_cnt;
    logic [POS_W:0]    w_tlr;
    logic [POS_W-1:0]  w_cfg_len;

    // Child indexes, split point, node width, stack top and requested length.
    always_comb begin
        w_left    = {r_node[NODE_W-2:0], 1'b0};
        w_right   = {r_node[NODE_W-2:0], 1'b1};
        w_lh      = {1'b0, r_lo} + {1'b0, r_hi};
        w_mid     = w_lh[POS_W:1];
        w_cnt     = r_tr - r_tl + 1'b1;
        w_tlr     = {1'b0, r_tl} + {1'b0, r_tr};
        w_top     = STK_AW'(r_sp - 1'b1);
        if (i_cfg_data == '0) begin
            w_cfg_len = POS_W'(1);
        end else if (32'(i_cfg_data) > MAX_LEN) begin
            w_cfg_len = POS_W'(MAX_LEN);
        end else begin
            w_cfg_len = i_cfg_data;
        end
    end

    // Handshake outputs.
    assign o_in_stall  = (r_state != ST_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_range_sum = r_out_sum;

    // Sequencer: next state and datapath control.
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_sp        = r_sp;
        n_addr      = r_addr;
        n_len       = r_len;
        n_out_valid = r_out_valid && i_out_stall;
        n_kind      = r_kind;
        n_u         = r_u;
        n_v         = r_v;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_acc       = r_acc;
        n_node      = r_node;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_merge     = r_merge;
        n_tl        = r_tl;
        n_tr        = r_tr;
        n_tc_in     = r_tc_in;
        n_ts_in     = r_ts_in;
        n_pc        = r_pc;
        n_ps        = r_ps;
        n_tri       = r_tri;
        n_t1        = r_t1;
        n_out_sum   = r_out_sum;
        w_push      = 1'b0;
        w_push_node = r_node;
        w_push_lo   = r_lo;
        w_push_hi   = r_hi;
        w_push_mg   = 1'b0;
        w_we_sum    = 1'b0;
        w_we_tag    = 1'b0;
        w_wd_sum    = '0;
        w_wd_tc     = '0;
        w_wd_ts     = '0;
        w_mul_req   = '0;

        case (r_state)
            // Sweep the node store to zero.
            ST_CLEAR: begin
                w_we_sum = 1'b1;
                w_we_tag = 1'b1;
                n_addr   = r_addr + 1'b1;
                if (&r_addr) begin
                    n_state = ST_IDLE;
                end
            end

            // Length writes take priority over requests.
            ST_IDLE: begin
                if (i_cfg_valid) begin
                    n_len   = w_cfg_len;
                    n_addr  = '0;
                    n_state = ST_CLEAR;
                end else if (i_in_valid) begin
                    n_kind  = i_kind;
                    n_u     = i_range_low;
                    n_v     = i_range_high;
                    n_a     = modred(i_slope);
                    n_b     = modred(i_offset);
                    n_state = ST_ANCHOR;
                end
            end

            // Constant term of the progression: offset - slope*range_low.
            ST_ANCHOR: begin
                w_mul_req.start = 1'b1;
                w_mul_req.x     = r_a;
                w_mul_req.y     = VAL_W'(r_u);
                n_state         = ST_ANCHOR_W;
            end

            ST_ANCHOR_W: begin
                if (w_mul_rsp.done) begin
                    n_c         = modsub(r_b, w_mul_rsp.prod);
                    n_acc       = '0;
                    w_push      = 1'b1;
                    w_push_node = NODE_W'(1);
                    w_push_lo   = POS_W'(1);
                    w_push_hi   = r_len;
                    w_push_mg   = 1'b0;
                    n_sp        = r_sp + 1'b1;
                    n_state     = ST_POP;
                end
            end

            // Take the next frame, or finish the walk.
            ST_POP: begin
                if (r_sp == '0) begin
                    n_state = r_kind ? ST_DONE : ST_IDLE;
                end else begin
                    n_node  = r_stk_node[w_top];
                    n_lo    = r_stk_lo[w_top];
                    n_hi    = r_stk_hi[w_top];
                    n_merge = r_stk_mg[w_top];
                    n_sp    = r_sp - 1'b1;
                    n_state = ST_VISIT;
                end
            end

            // Classify the frame against the request range.
            ST_VISIT: begin
                if (r_merge) begin
                    n_addr  = w_left;
                    n_state = ST_MG_W1;
                end else if ((r_hi < r_u) || (r_lo > r_v)) begin
                    n_state = ST_POP;
                end else if ((r_u <= r_lo) && (r_hi <= r_v)) begin
                    n_addr = r_node;
                    if (r_kind) begin
                        n_state = ST_COV_W;
                    end else begin
                        n_tl    = r_lo;
                        n_tr    = r_hi;
                        n_tc_in = r_c;
                        n_ts_in = r_a;
                        n_ret   = ST_POP;
                        n_state = ST_AP_TRI;
                    end
                end else begin
                    n_addr  = r_node;
                    n_state = ST_PD_W;
                end
            end

            // Fully covered node on a query: accumulate its sum.
            ST_COV_W: begin
                n_state = ST_COV;
            end

            ST_COV: begin
                n_acc   = modadd(r_acc, w_rd_sum);
                n_state = ST_POP;
            end

            // Push the pending tag down to the left child, then the right.
            ST_PD_W: begin
                n_state = ST_PD;
            end

            ST_PD: begin
                n_pc    = w_rd_tc;
                n_ps    = w_rd_ts;
                n_tc_in = w_rd_tc;
                n_ts_in = w_rd_ts;
                n_tl    = r_lo;
                n_tr    = w_mid;
                n_addr  = w_left;
                n_ret   = ST_PD_R;
                n_state = ST_AP_TRI;
            end

            ST_PD_R: begin
                n_tc_in = r_pc;
                n_ts_in = r_ps;
                n_tl    = w_mid + 1'b1;
                n_tr    = r_hi;
                n_addr  = w_right;
                n_ret   = ST_PD_CLR;
                n_state = ST_AP_TRI;
            end

            ST_PD_CLR: begin
                n_addr  = r_node;
                n_state = ST_PD_ZERO;
            end

            // Clear the parent's tags; its sum is kept.
            ST_PD_ZERO: begin
                w_we_tag = 1'b1;
                n_state  = r_kind ? ST_PUSH_R : ST_PUSH_MG;
            end

            // Push merge frame (updates only), right child and left child.
            ST_PUSH_MG: begin
                w_push    = 1'b1;
                w_push_mg = 1'b1;
                n_sp      = r_sp + 1'b1;
                n_state   = ST_PUSH_R;
            end

            ST_PUSH_R: begin
                w_push      = 1'b1;
                w_push_node = w_right;
                w_push_lo   = w_mid + 1'b1;
                w_push_hi   = r_hi;
                n_sp        = r_sp + 1'b1;
                n_state     = ST_PUSH_L;
            end

            ST_PUSH_L: begin
                w_push      = 1'b1;
                w_push_node = w_left;
                w_push_lo   = r_lo;
                w_push_hi   = w_mid;
                n_sp        = r_sp + 1'b1;
                n_state     = ST_POP;
            end

            // Rebuild a parent's sum from its two children.
            ST_MG_W1: begin
                n_state = ST_MG_1;
            end

            ST_MG_1: begin
                n_t1    = w_rd_sum;
                n_addr  = w_right;
                n_state = ST_MG_W2;
            end

            ST_MG_W2: begin
                n_state = ST_MG_2;
            end

            ST_MG_2: begin
                n_t1    = modadd(r_t1, w_rd_sum);
                n_addr  = r_node;
                n_state = ST_MG_WR;
            end

            ST_MG_WR: begin
                w_we_sum = 1'b1;
                w_wd_sum = r_t1;
                n_state  = ST_POP;
            end

            // Tag application: triangular weight first.
            ST_AP_TRI: begin
                w_mul_req.start = 1'b1;
                w_mul_req.x     = VAL_W'(w_tlr);
                w_mul_req.y     = VAL_W'(w_cnt);
                n_state         = ST_AP_M1;
            end

            ST_AP_M1: begin
                if (w_mul_rsp.done) begin
                    n_tri           = {1'b0, w_mul_rsp.prod[VAL_W-1:1]};
                    w_mul_req.start = 1'b1;
                    w_mul_req.x     = r_tc_in;
                    w_mul_req.y     = VAL_W'(w_cnt);
                    n_state         = ST_AP_M2;
                end
            end

            ST_AP_M2: begin
                if (w_mul_rsp.done) begin
                    n_t1            = w_mul_rsp.prod;
                    w_mul_req.start = 1'b1;
                    w_mul_req.x     = r_ts_in;
                    w_mul_req.y     = r_tri;
                    n_state         = ST_AP_M3;
                end
            end

            ST_AP_M3: begin
                if (w_mul_rsp.done) begin
                    n_t1    = modadd(r_t1, w_mul_rsp.prod);
                    n_state = ST_AP_WR;
                end
            end

            ST_AP_WR: begin
                w_we_sum = 1'b1;
                w_we_tag = 1'b1;
                w_wd_sum = modadd(w_rd_sum, r_t1);
                w_wd_tc  = modadd(w_rd_tc, r_tc_in);
                w_wd_ts  = modadd(w_rd_ts, r_ts_in);
                n_state  = r_ret;
            end

            // Hand the sum to the output register once it is free.
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_sum   = r_acc;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_ret       <= ST_POP;
            r_sp        <= '0;
            r_addr      <= '0;
            r_len       <= POS_W'(MAX_LEN);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_sp        <= n_sp;
            r_addr      <= n_addr;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_u       <= n_u;
        r_v       <= n_v;
        r_a       <= n_a;
        r_b       <= n_b;
        r_c       <= n_c;
        r_acc     <= n_acc;
        r_node    <= n_node;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_merge   <= n_merge;
        r_tl      <= n_tl;
        r_tr      <= n_tr;
        r_tc_in   <= n_tc_in;
        r_ts_in   <= n_ts_in;
        r_pc      <= n_pc;
        r_ps      <= n_ps;
        r_tri     <= n_tri;
        r_t1      <= n_t1;
        r_out_sum <= n_out_sum;
    end

    // Walk stack writes.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stk_node[r_sp[STK_AW-1:0]] <= w_push_node;
            r_stk_lo[r_sp[STK_AW-1:0]]   <= w_push_lo;
            r_stk_hi[r_sp[STK_AW-1:0]]   <= w_push_hi;
            r_stk_mg[r_sp[STK_AW-1:0]]   <= w_push_mg;
        end
    end

    // Node sums and the two tag fields.
    rpas_ram #(.AW(NODE_W)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_sum),
        .i_addr  (r_addr),
        .i_wdata (w_wd_sum),
        .o_rdata (w_rd_sum)
    );

    rpas_ram #(.AW(NODE_W)) u_tc_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_tag),
        .i_addr  (r_addr),
        .i_wdata (w_wd_tc),
        .o_rdata (w_rd_tc)
    );

    rpas_ram #(.AW(NODE_W)) u_ts_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_tag),
        .i_addr  (r_addr),
        .i_wdata (w_wd_ts),
        .o_rdata (w_rd_ts)
    );

    // Shared modular multiplier.
    rpas_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    // A length write always starts a clearing pass.
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> r_state == ST_CLEAR)
        else $error("length write did not start a clearing pass");

    // The walk stack is empty whenever the block waits for a request.
    a_idle_stack_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> r_sp == '0)
        else $error("walk stack not empty while idle");

    // The stored length stays inside its legal range.
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len != '0 && 32'(r_len) <= MAX_LEN)
        else $error("stored length out of range");

    // A result appears only when a query walk has finished.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_DONE && $past(r_kind))
        else $error("result raised outside a finished query");

endmodule

// File: bench/range_progression_add_sum_tree_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Range progression add / range sum tree: testbench
// Drives progression updates and range-sum queries through the valid/stall
// handshake and checks every sum against a flat-array model of the positions.
// The run covers directed corner cases, length register extremes, random
// traffic under several idle and stall mixes, and a long output hold-off.
// ---------------------------------------------------------------------------
module range_progression_add_sum_tree_tb;
    import rpas_pkg::*;

    localparam int          LEAVES      = 1024;
    localparam longint      PRIME       = 64'd1000000007;
    localparam int          CYCLE_LIMIT = 30000000;
    localparam int          SETTLE      = 8000;
    localparam int          HOLD_CYCLES = 4000;
    localparam logic        KIND_ADD    = 1'b0;
    localparam logic        KIND_QUERY  = 1'b1;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    logic             i_kind;
    logic [POS_W-1:0] i_range_low;
    logic [POS_W-1:0] i_range_high;
    logic [VAL_W-1:0] i_slope;
    logic [VAL_W-1:0] i_offset;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [VAL_W-1:0] o_range_sum;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [POS_W-1:0] i_cfg_data;

    // Model state: current length and every position value.
    int          model_len;
    longint      position_value [1:LEAVES];
    logic [VAL_W-1:0] expected_sums [$];

    int  gap_pct;
    int  stall_pct;
    bit  hold_output;
    int  error_count;
    int  item_count;
    int  query_count;
    int  checked_count;
    int  cycle_count = 0;

    range_progression_add_sum_tree u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .i_slope      (i_slope),
        .i_offset     (i_offset),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_range_sum  (o_range_sum),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle counter with a hard limit on the run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[range_progression_add_sum_tree] ERROR");
            $finish;
        end
    end

    // Clear the model array, as every length write does.
    function automatic void clear_positions();
        for (int i = 1; i <= LEAVES; i++) position_value[i] = 0;
    endfunction

    // Apply one accepted request to the model; a query queues its expected sum.
    function automatic void predict_request(input logic k, input logic [POS_W-1:0] lo,
                                            input logic [POS_W-1:0] hi,
                                            input logic [VAL_W-1:0] s,
                                            input logic [VAL_W-1:0] o);
        longint a;
        longint b;
        longint acc;
        int     first;
        int     last;
        a     = longint'(s) % PRIME;
        b     = longint'(o) % PRIME;
        acc   = 0;
        first = (lo < 1) ? 1 : int'(lo);
        last  = (int'(hi) > model_len) ? model_len : int'(hi);
        for (int i = first; i <= last; i++) begin
            if (k == KIND_QUERY)
                acc = (acc + position_value[i]) % PRIME;
            else
                position_value[i] = (position_value[i] +
                                     (a * longint'(i - int'(lo))) % PRIME + b) % PRIME;
        end
        if (k == KIND_QUERY) begin
            expected_sums.push_back(VAL_W'(acc));
            query_count++;
        end
    endfunction

    task automatic report_mismatch(input logic [VAL_W-1:0] got, input logic [VAL_W-1:0] want,
                                   input bit unexpected);
        error_count++;
        if (unexpected)
            $display("mismatch: result %0d arrived with no sum pending", got);
        else
            $display("mismatch: range_sum %0d, expected %0d", got, want);
    endtask

    // Receiver stall, random or held for a long stretch.
    always @(negedge i_clk) begin
        if (hold_output)
            i_out_stall <= 1'b1;
        else
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Long hold-off, counted in cycles here.
    task automatic hold_outputs();
        hold_output = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_output = 1'b0;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_sums.size() == 0) begin
                report_mismatch(o_range_sum, '0, 1'b1);
            end else begin
                if (o_range_sum !== expected_sums[0])
                    report_mismatch(o_range_sum, expected_sums[0], 1'b0);
                void'(expected_sums.pop_front());
                checked_count++;
            end
        end
    end

    // Send one request; valid is left high after acceptance until the next step.
    task automatic send_request(input logic k, input logic [POS_W-1:0] lo,
                                input logic [POS_W-1:0] hi, input logic [VAL_W-1:0] s,
                                input logic [VAL_W-1:0] o);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= k;
        i_range_low  <= lo;
        i_range_high <= hi;
        i_slope      <= s;
        i_offset     <= o;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_request(k, lo, hi, s, o);
        item_count++;
    endtask

    // Drop the request line and wait until every sum has come back.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge i_clk);
    endtask

    // Write the length register while idle.
    task automatic write_length(input logic [POS_W-1:0] value);
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        model_len = (value < 1) ? 1 : ((value > LEAVES) ? LEAVES : int'(value));
        clear_positions();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One random request over the current length.
    task automatic send_random_request();
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        logic             k;
        k = $urandom_range(0, 1);
        if ($urandom_range(0, 99) < 6) begin
            lo = POS_W'($urandom);
            hi = POS_W'($urandom);
        end else begin
            lo = POS_W'($urandom_range(0, model_len + 1));
            hi = POS_W'($urandom_range(int'(lo), model_len + 1));
        end
        send_request(k, lo, hi, VAL_W'($urandom), VAL_W'($urandom));
    endtask

    task automatic test_directed();
        send_request(KIND_ADD, 1, 1024, VAL_W'(MODP - 1), VAL_W'(MODP - 1));
        send_request(KIND_QUERY, 1, 1024, 0, 0);
        send_request(KIND_QUERY, 1, 1, 0, 0);
        send_request(KIND_QUERY, 1024, 1024, 0, 0);
        // Inputs above the modulus are reduced first.
        send_request(KIND_ADD, 3, 900, '1, VAL_W'(MODP));
        send_request(KIND_QUERY, 2, 901, '1, '1);
        // Progression anchored at position zero.
        send_request(KIND_ADD, 0, 10, 7, 5);
        send_request(KIND_QUERY, 0, 12, 0, 0);
        // Range reaching past the array.
        send_request(KIND_ADD, 1000, 2047, 123456789, 987654321);
        send_request(KIND_QUERY, 1020, 2047, 0, 0);
        send_request(KIND_QUERY, 1025, 2047, 0, 0);
        // Empty range.
        send_request(KIND_ADD, 600, 599, 11, 13);
        send_request(KIND_QUERY, 600, 599, 0, 0);
        send_request(KIND_QUERY, 599, 600, 0, 0);
        send_request(KIND_ADD, 512, 512, 0, VAL_W'(MODP - 1));
        send_request(KIND_QUERY, 511, 513, 0, 0);
        send_request(KIND_QUERY, 1, 1024, 0, 0);
    endtask

    task automatic test_length_extremes();
        // Zero acts as one.
        write_length(0);
        send_request(KIND_ADD, 0, 2047, '1, '1);
        send_request(KIND_QUERY, 1, 1, 0, 0);
        send_request(KIND_QUERY, 0, 2047, 0, 0);
        // Above the leaf count acts as the leaf count.
        write_length(2047);
        send_request(KIND_QUERY, 1, 1024, 0, 0);
        send_request(KIND_ADD, 1, 1024, 1, 0);
        send_request(KIND_QUERY, 1, 1024, 0, 0);
        write_length(1);
        send_request(KIND_ADD, 1, 1, 5, 9);
        send_request(KIND_QUERY, 1, 1, 0, 0);
        write_length(2);
        send_request(KIND_ADD, 1, 2, 3, 4);
        send_request(KIND_QUERY, 2, 2, 0, 0);
    endtask

    task automatic test_random_phase(input int gaps, input int stalls, input int count);
        gap_pct   = gaps;
        stall_pct = stalls;
        if ($urandom_range(0, 9) == 0)
            write_length(POS_W'($urandom));
        else
            write_length(POS_W'($urandom_range(1, 40)));
        for (int n = 0; n < count; n++) send_random_request();
    endtask

    task automatic test_backpressure();
        gap_pct   = 0;
        stall_pct = 0;
        write_length(16);
        fork
            hold_outputs();
            for (int n = 0; n < 30; n++) send_random_request();
        join
        drain_results();
        for (int n = 0; n < 20; n++) send_random_request();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_kind       = 1'b0;
        i_range_low  = '0;
        i_range_high = '0;
        i_slope      = '0;
        i_offset     = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        gap_pct      = 0;
        stall_pct    = 0;
        hold_output  = 1'b0;
        error_count  = 0;
        item_count   = 0;
        query_count  = 0;
        checked_count = 0;
        model_len    = LEAVES;
        clear_positions();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_length_extremes();
        for (int r = 0; r < 2; r++) begin
            test_random_phase(0, 0, 180);
            test_random_phase(48, 0, 180);
            test_random_phase(0, 48, 180);
            test_random_phase(13, 13, 180);
        end
        test_backpressure();

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        $display("Sent %0d requests (%0d queries, %0d sums checked) over lengths 1..1024,",
                 item_count, query_count, checked_count);
        $display("with idle and stall mixes and a long output hold-off; %0d mismatches.",
                 error_count);
        if (error_count == 0 && expected_sums.size() == 0)
            $display("[range_progression_add_sum_tree] OK");
        else
            $display("[range_progression_add_sum_tree] ERROR");
        $finish;
    end

endmodule

// File: files.f
hdl/rpas_pkg.sv
hdl/rpas_modmul.sv
hdl/rpas_ram.sv
hdl/range_progression_add_sum_tree.sv
bench/range_progression_add_sum_tree_tb.sv
